FILE: hw/rtl/kwm_pkg.sv
// Shared types for the k-way merge heap: controller commands and datapath status.
// Depends on nothing; the controller, the datapath and the top level import it.

package kwm_pkg;

   // Fixed widths of the lane field and of the lane-count register.
   localparam int LANE_BITS = 4;
   localparam int CSR_BITS  = 5;

   // Next value of the heap position register.
   typedef enum logic [2:0] {
      POS_HOLD   = 3'd0,
      POS_SIZE   = 3'd1,
      POS_ZERO   = 3'd2,
      POS_PARENT = 3'd3,
      POS_CHILD  = 3'd4
   } pos_sel_type;

   // Heap size update.
   typedef enum logic [1:0] {
      SZ_HOLD = 2'd0,
      SZ_INC  = 2'd1,
      SZ_DEC  = 2'd2
   } size_op_type;

   // Addresses presented to the two heap memory read ports.
   typedef enum logic [1:0] {
      RD_PARENT = 2'd0,
      RD_POP    = 2'd1,
      RD_CHILD  = 2'd2
   } rd_sel_type;

   // Data written at the current heap position.
   typedef enum logic [1:0] {
      WR_X     = 2'd0,
      WR_A     = 2'd1,
      WR_CHILD = 2'd2
   } wr_sel_type;

   // Source of the moving entry register.
   typedef enum logic [1:0] {
      X_HOLD = 2'd0,
      X_LOAD = 2'd1,
      X_LAST = 2'd2
   } x_sel_type;

   // What, if anything, is presented as a result word.
   typedef enum logic [1:0] {
      EM_NONE = 2'd0,
      EM_X    = 2'd1,
      EM_A    = 2'd2,
      EM_DONE = 2'd3
   } emit_type;

   // Command from controller to datapath, valid for one cycle.
   typedef struct packed {
      pos_sel_type pos_sel;
      size_op_type size_op;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      x_sel_type   x_sel;
      emit_type    emit;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic size_zero;
      logic size_full;
      logic pos_zero;
      logic x_lt_a;
      logic a_lt_x;
      logic dn_leaf;
      logic dn_stop;
   } status_type;

endpackage

FILE: hw/rtl/kwm_datapath.sv
// Datapath of the k-way merge heap: heap memory, moving entry, position, size, result word.
// Depends on kwm_pkg for the command and status structs.

module kwm_datapath
   import kwm_pkg::*;
#(
   parameter int MAX_LANES  = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  logic [LANE_BITS-1:0]         req_lane,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   output logic signed [VALUE_BITS-1:0] rsp_smallest,
   output logic [LANE_BITS-1:0]         rsp_source_lane,
   output logic                         rsp_done_res
);

   localparam int IDX_W     = $clog2(MAX_LANES);
   localparam int SZ_W      = $clog2(MAX_LANES + 1);
   localparam int EW        = VALUE_BITS + LANE_BITS;
   localparam int MEM_DEPTH = 1 << IDX_W;
   localparam int CH_W      = IDX_W + 2;

   // Heap order: value first (signed), then lane.
   function automatic logic entry_less(input logic [EW-1:0] a, input logic [EW-1:0] b);
      logic signed [VALUE_BITS-1:0] va;
      logic signed [VALUE_BITS-1:0] vb;
      va = a[EW-1:LANE_BITS];
      vb = b[EW-1:LANE_BITS];
      if (va != vb) begin
         return va < vb;
      end
      return a[LANE_BITS-1:0] < b[LANE_BITS-1:0];
   endfunction

   logic [EW-1:0]          mem [MEM_DEPTH];
   logic [EW-1:0]          rd_a_ff;
   logic [EW-1:0]          rd_b_ff;
   logic [EW-1:0]          x_ff;
   logic [EW-1:0]          x_in;
   logic [IDX_W-1:0]       pos_ff;
   logic [IDX_W-1:0]       pos_in;
   logic [SZ_W-1:0]        size_ff;
   logic [SZ_W-1:0]        size_in;
   logic [IDX_W-1:0]       parent;
   logic [CH_W-1:0]        left_w;
   logic [CH_W-1:0]        right_w;
   logic [CH_W-1:0]        size_w;
   logic                   left_ok;
   logic                   right_ok;
   logic [SZ_W-1:0]        size_m1;
   logic [IDX_W-1:0]       addr_a;
   logic [IDX_W-1:0]       addr_b;
   logic                   a_lt_x_raw;
   logic                   a_wins;
   logic [EW-1:0]          first_pick;
   logic                   b_wins;
   logic [EW-1:0]          child_data;
   logic [IDX_W-1:0]       child_idx;
   logic [EW-1:0]          wr_data;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [VALUE_BITS-1:0]  res_value_ff;
   logic [VALUE_BITS-1:0]  res_value_in;
   logic [LANE_BITS-1:0]   res_lane_ff;
   logic [LANE_BITS-1:0]   res_lane_in;
   logic                   res_done_ff;
   logic                   res_done_in;

   // Tree neighbours of the current position.
   assign parent   = (pos_ff - IDX_W'(1)) >> 1;
   assign left_w   = {1'b0, pos_ff, 1'b1};
   assign right_w  = left_w + CH_W'(1);
   assign size_w   = CH_W'(size_ff);
   assign left_ok  = left_w < size_w;
   assign right_ok = right_w < size_w;
   assign size_m1  = size_ff - SZ_W'(1);

   // Read port addresses.
   always_comb begin
      case (cmd.rd_sel)
         RD_PARENT: begin
            addr_a = parent;
            addr_b = parent;
         end
         RD_POP: begin
            addr_a = '0;
            addr_b = size_m1[IDX_W-1:0];
         end
         RD_CHILD: begin
            addr_a = left_w[IDX_W-1:0];
            addr_b = right_w[IDX_W-1:0];
         end
         default: begin
            addr_a = '0;
            addr_b = '0;
         end
      endcase
   end

   // Sift-down choice: the smaller child if it beats the moving entry.
   assign a_lt_x_raw = entry_less(rd_a_ff, x_ff);
   assign a_wins     = left_ok && a_lt_x_raw;
   assign first_pick = a_wins ? rd_a_ff : x_ff;
   assign b_wins     = right_ok && entry_less(rd_b_ff, first_pick);
   assign child_data = b_wins ? rd_b_ff : rd_a_ff;
   assign child_idx  = b_wins ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];

   // Write data selection.
   always_comb begin
      case (cmd.wr_sel)
         WR_X:     wr_data = x_ff;
         WR_A:     wr_data = rd_a_ff;
         WR_CHILD: wr_data = child_data;
         default:  wr_data = x_ff;
      endcase
   end

   // Heap memory: one write port at the current position, two registered reads.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[pos_ff] <= wr_data;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   // Moving entry, position and size.
   always_comb begin
      case (cmd.x_sel)
         X_LOAD:  x_in = {req_value, req_lane};
         X_LAST:  x_in = rd_b_ff;
         default: x_in = x_ff;
      endcase
      case (cmd.pos_sel)
         POS_SIZE:   pos_in = size_ff[IDX_W-1:0];
         POS_ZERO:   pos_in = '0;
         POS_PARENT: pos_in = parent;
         POS_CHILD:  pos_in = child_idx;
         default:    pos_in = pos_ff;
      endcase
      case (cmd.size_op)
         SZ_INC:  size_in = size_ff + SZ_W'(1);
         SZ_DEC:  size_in = size_m1;
         default: size_in = size_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      pos_ff <= pos_in;
      if (reset) begin
         size_ff <= '0;
      end else begin
         size_ff <= size_in;
      end
   end

   // Result word register.
   always_comb begin
      rsp_valid_in = cmd.emit != EM_NONE;
      res_value_in = res_value_ff;
      res_lane_in  = res_lane_ff;
      res_done_in  = res_done_ff;
      case (cmd.emit)
         EM_X: begin
            res_value_in = x_ff[EW-1:LANE_BITS];
            res_lane_in  = x_ff[LANE_BITS-1:0];
            res_done_in  = 1'b0;
         end
         EM_A: begin
            res_value_in = rd_a_ff[EW-1:LANE_BITS];
            res_lane_in  = rd_a_ff[LANE_BITS-1:0];
            res_done_in  = 1'b0;
         end
         EM_DONE: begin
            res_value_in = '0;
            res_lane_in  = '0;
            res_done_in  = 1'b1;
         end
         default: begin
            res_value_in = res_value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_value_ff <= res_value_in;
      res_lane_ff  <= res_lane_in;
      res_done_ff  <= res_done_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_smallest    = res_value_ff;
   assign rsp_source_lane = res_lane_ff;
   assign rsp_done_res    = res_done_ff;

   // Status back to the controller.
   assign status.size_zero = size_ff == '0;
   assign status.size_full = size_ff >= SZ_W'(MAX_LANES);
   assign status.pos_zero  = pos_ff == '0;
   assign status.x_lt_a    = entry_less(x_ff, rd_a_ff);
   assign status.a_lt_x    = a_lt_x_raw;
   assign status.dn_leaf   = !left_ok;
   assign status.dn_stop   = !a_wins && !b_wins;

endmodule

FILE: hw/rtl/kwm_ctrl.sv
// Controller of the k-way merge heap: lane-count register, fill/merge phase and sift sequencer.
// Depends on kwm_pkg for the command and status structs.

module kwm_ctrl
   import kwm_pkg::*;
#(
   parameter int MAX_LANES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_exhausted,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_BITS-1:0] csr_lanes_in_use,
   input  status_type          status,
   output cmd_type             cmd
);

   localparam int SZ_W = $clog2(MAX_LANES + 1);
   localparam int CW   = ((SZ_W > CSR_BITS) ? SZ_W : CSR_BITS) + 1;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_UP_CHK  = 9'b000000010,
      ST_UP_CMP  = 9'b000000100,
      ST_POP_RD  = 9'b000001000,
      ST_POP_SET = 9'b000010000,
      ST_DN_RD   = 9'b000100000,
      ST_DN_CMP  = 9'b001000000,
      ST_REP_RD  = 9'b010000000,
      ST_REP_CMP = 9'b100000000
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   logic [CSR_BITS-1:0] lanes_ff;
   logic [CSR_BITS-1:0] lanes_in;
   logic [SZ_W-1:0]     fill_count_ff;
   logic [SZ_W-1:0]     fill_count_in;
   logic                merging_ff;
   logic                merging_in;
   logic                last_ff;
   logic                last_in;
   logic [CW-1:0]       lanes_ext;
   logic [CW-1:0]       eff_lanes;
   logic [CW-1:0]       fill_inc;
   logic                fill_last;
   logic                insert_done;

   // Lane-count register; always ready.
   assign csr_ready = 1'b1;
   assign lanes_in  = (csr_valid && csr_ready) ? csr_lanes_in_use : lanes_ff;

   // Lanes in use, with zero taken as one and large values clamped.
   always_comb begin
      lanes_ext = CW'(lanes_ff);
      if (lanes_ext == '0) begin
         eff_lanes = CW'(1);
      end else if (lanes_ext > CW'(MAX_LANES)) begin
         eff_lanes = CW'(MAX_LANES);
      end else begin
         eff_lanes = lanes_ext;
      end
   end

   assign fill_inc  = CW'(fill_count_ff) + CW'(1);
   assign fill_last = fill_inc >= eff_lanes;
   assign busy      = state_ff != ST_IDLE;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      merging_in    = merging_ff;
      last_in       = last_ff;
      insert_done   = 1'b0;
      cmd.pos_sel   = POS_HOLD;
      cmd.size_op   = SZ_HOLD;
      cmd.rd_sel    = RD_POP;
      cmd.wr_en     = 1'b0;
      cmd.wr_sel    = WR_X;
      cmd.x_sel     = X_HOLD;
      cmd.emit      = EM_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.x_sel = X_LOAD;
               if (merging_ff) begin
                  state_in = req_exhausted ? ST_POP_RD : ST_REP_RD;
               end else begin
                  fill_count_in = fill_inc[SZ_W-1:0];
                  last_in       = fill_last;
                  if (!req_exhausted && !status.size_full) begin
                     cmd.pos_sel = POS_SIZE;
                     cmd.size_op = SZ_INC;
                     state_in    = ST_UP_CHK;
                  end else if (fill_last) begin
                     state_in = ST_POP_RD;
                  end
               end
            end
         end
         // Sift-up: read the parent, then compare and move one level.
         ST_UP_CHK: begin
            cmd.rd_sel = RD_PARENT;
            if (status.pos_zero) begin
               cmd.wr_en   = 1'b1;
               insert_done = 1'b1;
            end else begin
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.x_lt_a) begin
               cmd.wr_sel  = WR_A;
               cmd.pos_sel = POS_PARENT;
               state_in    = ST_UP_CHK;
            end else begin
               insert_done = 1'b1;
            end
         end
         // Pop: read top and last entry, or finish the run when empty.
         ST_POP_RD: begin
            cmd.rd_sel = RD_POP;
            if (status.size_zero) begin
               cmd.emit      = EM_DONE;
               merging_in    = 1'b0;
               fill_count_in = '0;
               state_in      = ST_IDLE;
            end else begin
               cmd.size_op = SZ_DEC;
               cmd.pos_sel = POS_ZERO;
               merging_in  = 1'b1;
               state_in    = ST_POP_SET;
            end
         end
         ST_POP_SET: begin
            cmd.emit  = EM_A;
            cmd.x_sel = X_LAST;
            state_in  = ST_DN_RD;
         end
         // Sift-down: read both children, then compare and move one level.
         ST_DN_RD: begin
            cmd.rd_sel = RD_CHILD;
            if (status.dn_leaf) begin
               cmd.wr_en = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.dn_stop) begin
               state_in = ST_IDLE;
            end else begin
               cmd.wr_sel  = WR_CHILD;
               cmd.pos_sel = POS_CHILD;
               state_in    = ST_DN_RD;
            end
         end
         // Refill and pop in one: the new word either leaves at once or replaces the top.
         ST_REP_RD: begin
            cmd.rd_sel = RD_POP;
            if (status.size_zero) begin
               cmd.emit = EM_X;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_REP_CMP;
            end
         end
         ST_REP_CMP: begin
            if (status.a_lt_x) begin
               cmd.emit    = EM_A;
               cmd.pos_sel = POS_ZERO;
               state_in    = ST_DN_RD;
            end else begin
               cmd.emit = EM_X;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (insert_done) begin
         state_in = last_ff ? ST_POP_RD : ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lanes_ff      <= CSR_BITS'(16);
         fill_count_ff <= '0;
         merging_ff    <= 1'b0;
         last_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lanes_ff      <= lanes_in;
         fill_count_ff <= fill_count_in;
         merging_ff    <= merging_in;
         last_ff       <= last_in;
      end
   end

endmodule

FILE: hw/rtl/k_way_merge_min_heap.sv
// K-way merge of up to MAX_LANES sorted signed streams through a min-heap of lane heads.
// Depends on kwm_pkg, kwm_ctrl and kwm_datapath.
//
// A run starts with a fill phase: one word per lane in use (its first value or an exhausted
// mark), no result until the last one. Every later word refills, or marks exhausted, the lane
// named by the previous result, and yields the smallest head and its lane (ties to the lower
// lane), or done once the heap is empty, after which the next run begins. Each result appears
// on rsp_* for exactly one cycle with rsp_valid high and cannot be held off, so the receiver
// must always take it. A word is taken when start is high and busy is low. The heap sits in a
// single memory and every sift moves one tree level per read state and compare-and-write state.
// A merge word finishes at once when the heap is empty, after the compare when it beats the
// current top and after a sift-down otherwise; a fill word finishes after its sift-up, if it
// inserts, plus the pop on the last one. The result of the last fill word follows its sift-up.
// The lane count is written through csr_*; the user must do so only while busy is low, as
// the block itself does not enforce it.

module k_way_merge_min_heap
   import kwm_pkg::*;
#(
   parameter int MAX_LANES  = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [LANE_BITS-1:0]         req_lane,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         req_exhausted,
   output logic                         rsp_valid,
   output logic signed [VALUE_BITS-1:0] rsp_smallest,
   output logic [LANE_BITS-1:0]         rsp_source_lane,
   output logic                         rsp_done_res,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_BITS-1:0]          csr_lanes_in_use
);

   cmd_type    cmd;
   status_type status;

   // Phase control and sift sequencing.
   kwm_ctrl #(
      .MAX_LANES (MAX_LANES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_exhausted    (req_exhausted),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_lanes_in_use (csr_lanes_in_use),
      .status           (status),
      .cmd              (cmd)
   );

   // Heap storage, comparisons and result word.
   kwm_datapath #(
      .MAX_LANES  (MAX_LANES),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_lane        (req_lane),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_smallest    (rsp_smallest),
      .rsp_source_lane (rsp_source_lane),
      .rsp_done_res    (rsp_done_res)
   );

endmodule

FILE: sim/k_way_merge_min_heap_test.sv
// Self-checking testbench for k_way_merge_min_heap: directed merges and random merge traffic,
// each result checked against a heap predictor held in the testbench.
// Depends on kwm_pkg and the k_way_merge_min_heap RTL only.

module k_way_merge_min_heap_test;
   timeunit 1ns;
   timeprecision 1ps;
   import kwm_pkg::*;

   localparam int LANE_COUNT    = 16;
   localparam int WIDTH         = 32;
   localparam int SETTLE_CYCLES = 30;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int PHASE_WORDS   = 256;

   // How the values of a generated stream are spread.
   typedef enum int {
      VAL_WIDE  = 0,
      VAL_TIGHT = 1,
      VAL_EDGE  = 2
   } value_mode_type;

   typedef struct packed {
      logic signed [WIDTH-1:0] value;
      logic [LANE_BITS-1:0]    lane;
   } head_type;

   typedef struct packed {
      logic signed [WIDTH-1:0] smallest;
      logic [LANE_BITS-1:0]    source_lane;
      logic                    done_res;
   } merge_result_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [LANE_BITS-1:0]    req_lane;
   logic signed [WIDTH-1:0] req_value;
   logic                    req_exhausted;
   logic                    rsp_valid;
   logic signed [WIDTH-1:0] rsp_smallest;
   logic [LANE_BITS-1:0]    rsp_source_lane;
   logic                    rsp_done_res;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_BITS-1:0]     csr_lanes_in_use;

   // Predictor state: the heap of lane heads, the fill progress and the lane count.
   head_type             heap_model[LANE_COUNT];
   int                   heap_count;
   int                   fill_count;
   bit                   merge_phase;
   logic [CSR_BITS-1:0]  lane_setting;
   logic [LANE_BITS-1:0] popped_lane;

   merge_result_type pending_q[$];
   int               lane_vals[LANE_COUNT][$];
   int               fail_count  = 0;
   int               items_sent  = 0;
   int               gap_pct     = 0;
   int               cycle_count = 0;

   k_way_merge_min_heap #(
      .MAX_LANES(LANE_COUNT),
      .VALUE_BITS(WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_lane(req_lane),
      .req_value(req_value),
      .req_exhausted(req_exhausted),
      .rsp_valid(rsp_valid),
      .rsp_smallest(rsp_smallest),
      .rsp_source_lane(rsp_source_lane),
      .rsp_done_res(rsp_done_res),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_lanes_in_use(csr_lanes_in_use)
   );

   // Free-running clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Heap order is by signed value, and a tie goes to the lower lane.
   function automatic bit head_less(head_type a, head_type b);
      if (a.value != b.value) return $signed(a.value) < $signed(b.value);
      return a.lane < b.lane;
   endfunction

   // Insert and sift up; an insert into a full heap is dropped.
   function automatic void heap_push(head_type item);
      int       i;
      int       p;
      head_type t;
      if (heap_count >= LANE_COUNT) return;
      i = heap_count;
      heap_count++;
      heap_model[i] = item;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!head_less(heap_model[i], heap_model[p])) break;
         t = heap_model[i];
         heap_model[i] = heap_model[p];
         heap_model[p] = t;
         i = p;
      end
   endfunction

   // Remove the top, move the last entry to the root and sift it down.
   function automatic head_type heap_take();
      head_type top;
      head_type t;
      int       i;
      int       l;
      int       r;
      int       m;
      top = heap_model[0];
      heap_count--;
      heap_model[0] = heap_model[heap_count];
      i = 0;
      while (1) begin
         l = 2 * i + 1;
         r = l + 1;
         m = i;
         if (l < heap_count && head_less(heap_model[l], heap_model[m])) m = l;
         if (r < heap_count && head_less(heap_model[r], heap_model[m])) m = r;
         if (m == i) break;
         t = heap_model[i];
         heap_model[i] = heap_model[m];
         heap_model[m] = t;
         i = m;
      end
      return top;
   endfunction

   // A lane count of zero acts as one; anything above the heap depth acts as the depth.
   function automatic int lanes_effective();
      if (lane_setting == 0) return 1;
      if (lane_setting > LANE_COUNT) return LANE_COUNT;
      return lane_setting;
   endfunction

   // Advance the predictor by one word; returns 1 when the word yields a result.
   function automatic bit predict_word(input logic [LANE_BITS-1:0] lane,
                                       input logic signed [WIDTH-1:0] value,
                                       input logic exh, output merge_result_type res);
      head_type item;
      res = '0;
      item.value = value;
      item.lane  = lane;
      if (!exh) heap_push(item);
      if (!merge_phase) begin
         fill_count++;
         if (fill_count < lanes_effective()) return 0;
      end
      if (heap_count == 0) begin
         // Heap empty: done, and the next word starts a new fill.
         res.done_res = 1'b1;
         merge_phase  = 0;
         fill_count   = 0;
      end else begin
         item = heap_take();
         res.smallest    = item.value;
         res.source_lane = item.lane;
         popped_lane     = item.lane;
         merge_phase     = 1;
      end
      return 1;
   endfunction

   function automatic int pick_value(value_mode_type mode);
      case (mode)
         VAL_WIDE:  return $urandom;
         VAL_TIGHT: return $urandom_range(7) - 4;
         default:   return ($urandom_range(1) ? 32'sh7fff_fff0 : 32'sh8000_0000) +
                           $urandom_range(15);
      endcase
   endfunction

   // Send one word, with idle cycles before it, and predict its result.
   task automatic send_word(input logic [LANE_BITS-1:0] lane,
                            input logic signed [WIDTH-1:0] value, input logic exh);
      merge_result_type res;
      // Each cycle the sender idles with a chance of gap_pct in a hundred.
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start         = 1'b1;
      req_lane      = lane;
      req_value     = value;
      req_exhausted = exh;
      do @(posedge clock); while (busy);
      if (predict_word(lane, value, exh, res)) pending_q.insert(pending_q.size(), res);
      items_sent++;
   endtask

   // Stop sending and wait until every result is in and the block has gone quiet.
   task automatic wait_block_idle();
      @(negedge clock);
      start = 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_lanes(input logic [CSR_BITS-1:0] setting);
      wait_block_idle();
      @(negedge clock);
      csr_valid        = 1'b1;
      csr_lanes_in_use = setting;
      do @(posedge clock); while (!csr_ready);
      lane_setting = setting;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Feed a lane its next stream element, or its exhausted mark once the stream is used up.
   task automatic offer_head(input logic [LANE_BITS-1:0] lane);
      if (lane_vals[lane].size() != 0) send_word(lane, lane_vals[lane].pop_front(), 1'b0);
      else send_word(lane, $urandom, 1'b1);
   endtask

   // Build sorted streams for n consecutive lanes (modulo the lane range), clearing the rest.
   task automatic load_streams(input int n, input int first_lane, input int max_len,
                               input value_mode_type mode);
      logic [LANE_BITS-1:0] lane;
      int                   len;
      foreach (lane_vals[i]) lane_vals[i].delete();
      for (int k = 0; k < n; k++) begin
         lane = LANE_BITS'(first_lane + k);
         len  = $urandom_range(max_len, 0);
         repeat (len) lane_vals[lane].insert(lane_vals[lane].size(), pick_value(mode));
         lane_vals[lane].sort();
      end
   endtask

   // A well-formed run: one fill word per lane, then refill whichever lane was popped.
   task automatic play_merge(input int n, input int first_lane);
      for (int k = 0; k < n; k++) offer_head(LANE_BITS'(first_lane + k));
      while (merge_phase) offer_head(popped_lane);
   endtask

   // Bring the block back to the start of a fill with exhausted marks only.
   task automatic drain_to_fill();
      while (merge_phase || fill_count != 0)
         send_word(merge_phase ? popped_lane : LANE_BITS'($urandom), $urandom, 1'b1);
   endtask

   // Words with no regard for the protocol: repeated, wrong or missing lanes.
   task automatic send_noise(input int count);
      repeat (count) send_word(LANE_BITS'($urandom), $urandom, $urandom_range(3) == 0);
   endtask

   // Extreme values, a tie between lanes, and the top lane numbers.
   task automatic test_extreme_values();
      write_lanes(2);
      load_streams(2, 14, 0, VAL_WIDE);
      lane_vals[14].insert(lane_vals[14].size(), 32'sh8000_0000);
      lane_vals[14].insert(lane_vals[14].size(), 32'sh7fff_ffff);
      lane_vals[15].insert(lane_vals[15].size(), 32'sh8000_0000);
      lane_vals[15].insert(lane_vals[15].size(), -1);
      play_merge(2, 14);
   endtask

   // Every lane exhausted in the fill gives done on the last fill word.
   task automatic test_all_exhausted();
      write_lanes(3);
      load_streams(3, 5, 0, VAL_WIDE);
      play_merge(3, 5);
   endtask

   // A lane count of zero behaves as a single lane.
   task automatic test_zero_lane_count();
      write_lanes(0);
      load_streams(1, 9, 0, VAL_WIDE);
      lane_vals[9].insert(lane_vals[9].size(), 12345);
      play_merge(1, 9);
   endtask

   // Lowering and raising the lane count part-way through a fill.
   task automatic test_lane_count_change();
      write_lanes(5);
      for (int k = 0; k < 3; k++) send_word(LANE_BITS'(k), pick_value(VAL_WIDE), 1'b0);
      write_lanes(2);
      send_word(4'd3, 32'sd7, 1'b0);
      drain_to_fill();
      write_lanes(2);
      send_word(4'd8, -32'sd5, 1'b0);
      write_lanes(3);
      send_word(4'd9, -32'sd5, 1'b0);
      send_word(4'd10, 32'sd0, 1'b1);
      drain_to_fill();
   endtask

   // Mostly well-formed merges with random content, some noise, the odd lane-count change.
   task automatic run_random_phase(input int pct, input int target);
      int stop_at;
      int n;
      int first_lane;
      gap_pct = pct;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         if ($urandom_range(2) == 0)
            write_lanes($urandom_range(3) == 0 ? CSR_BITS'($urandom_range(31))
                                               : CSR_BITS'($urandom_range(6)));
         if ($urandom_range(4) == 0) begin
            send_noise($urandom_range(10, 1));
            drain_to_fill();
         end else begin
            n          = lanes_effective();
            first_lane = $urandom_range(15);
            load_streams(n, first_lane, n > 6 ? 2 : 5, value_mode_type'($urandom_range(2)));
            play_merge(n, first_lane);
         end
      end
   endtask

   task automatic test_random_sender_gaps();
      write_lanes(31);
      run_random_phase(25, PHASE_WORDS);
   endtask

   task automatic test_random_heavy_gaps();
      write_lanes(1);
      run_random_phase(74, PHASE_WORDS);
   endtask

   task automatic test_random_back_to_back();
      write_lanes(16);
      run_random_phase(0, PHASE_WORDS);
   endtask

   // Compare each result word with the oldest expectation.
   always @(posedge clock) begin
      merge_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result word: smallest %0d lane %0d done %0b", $time,
                     rsp_smallest, rsp_source_lane, rsp_done_res);
            fail_count++;
         end else begin
            want = pending_q.pop_front();
            if (rsp_smallest !== want.smallest) begin
               $display("%0t: smallest expected %0d, got %0d", $time,
                        $signed(want.smallest), rsp_smallest);
               fail_count++;
            end
            if (rsp_source_lane !== want.source_lane) begin
               $display("%0t: source_lane expected %0d, got %0d", $time,
                        want.source_lane, rsp_source_lane);
               fail_count++;
            end
            if (rsp_done_res !== want.done_res) begin
               $display("%0t: done_res expected %0b, got %0b", $time,
                        want.done_res, rsp_done_res);
               fail_count++;
            end
         end
      end
   end

   // Guard against a hang.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_lane         = '0;
      req_value        = '0;
      req_exhausted    = 1'b0;
      csr_valid        = 1'b0;
      csr_lanes_in_use = '0;
      heap_count       = 0;
      fill_count       = 0;
      merge_phase      = 0;
      lane_setting     = CSR_BITS'(16);
      popped_lane      = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      gap_pct = 25;
      test_extreme_values();
      test_all_exhausted();
      test_zero_lane_count();
      test_lane_count_change();
      test_random_sender_gaps();
      test_random_heavy_gaps();
      test_random_back_to_back();

      wait_block_idle();
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
